@@ hdl/qte_pkg.sv @@
// Shared widths, constants and arctangent table for the quaternion to Euler converter.
package qte_pkg;

  // Operand and datapath widths
  localparam int QW      = 16;  // quaternion component, Q1.15
  localparam int PROD_W  = 32;  // component product, scale 2^30
  localparam int SUM_W   = 34;  // doubled sums of products
  localparam int CW      = 36;  // CORDIC x and y
  localparam int ZW      = 32;  // CORDIC angle, Q28
  localparam int SQ_W    = 62;  // square root remainder and root
  localparam int SQ_ITER = 31;  // root bits for a radicand up to 2^60
  localparam int TAB_LEN = 24;  // entries in the arctangent table

  localparam logic signed [ZW-1:0] PI_Q28      = 32'sd843314857;
  localparam logic signed [ZW-1:0] HALF_PI_Q28 = 32'sd421657428;
  localparam int PI_Q13      = 25736;
  localparam int HALF_PI_Q13 = 12868;

  // atan(2^-i) in Q28
  function automatic logic signed [ZW-1:0] atan_tab(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 32'sd210828714;
      1:  v = 32'sd124459457;
      2:  v = 32'sd65760959;
      3:  v = 32'sd33381290;
      4:  v = 32'sd16755422;
      5:  v = 32'sd8385879;
      6:  v = 32'sd4193963;
      7:  v = 32'sd2097109;
      8:  v = 32'sd1048571;
      9:  v = 32'sd524287;
      10: v = 32'sd262144;
      11: v = 32'sd131072;
      12: v = 32'sd65536;
      13: v = 32'sd32768;
      14: v = 32'sd16384;
      15: v = 32'sd8192;
      16: v = 32'sd4096;
      17: v = 32'sd2048;
      18: v = 32'sd1024;
      19: v = 32'sd512;
      20: v = 32'sd256;
      21: v = 32'sd128;
      22: v = 32'sd64;
      23: v = 32'sd32;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/qte_cordic.sv @@
// Pipelined vectoring CORDIC: atan2(y, x) in Q28, one stage per iteration.
module qte_cordic #(
  parameter int STAGES = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [qte_pkg::CW-1:0]  y_in,
  input  logic signed [qte_pkg::CW-1:0]  x_in,
  output logic signed [qte_pkg::ZW-1:0]  z_out
);
  import qte_pkg::*;

  logic signed [CW-1:0] xs [0:STAGES];
  logic signed [CW-1:0] ys [0:STAGES];
  logic signed [ZW-1:0] zs [0:STAGES];
  logic                 fix [0:STAGES];

  // Pre-rotation: zero numerator is exact, left half plane is turned by pi
  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in == '0) begin
        fix[0] <= 1'b1;
        zs[0]  <= (x_in >= 0) ? '0 : PI_Q28;
        xs[0]  <= x_in;
        ys[0]  <= y_in;
      end else if (x_in < 0) begin
        fix[0] <= 1'b0;
        zs[0]  <= (y_in > 0) ? PI_Q28 : -PI_Q28;
        xs[0]  <= -x_in;
        ys[0]  <= -y_in;
      end else begin
        fix[0] <= 1'b0;
        zs[0]  <= '0;
        xs[0]  <= x_in;
        ys[0]  <= y_in;
      end
    end
  end

  // Micro-rotations
  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        fix[i+1] <= fix[i];
        if (fix[i]) begin
          xs[i+1] <= xs[i];
          ys[i+1] <= ys[i];
          zs[i+1] <= zs[i];
        end else if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + atan_tab(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - atan_tab(i);
        end
      end
    end
  end

  assign z_out = zs[STAGES];

endmodule

@@ hdl/quaternion_to_euler_angles.sv @@
// Quaternion (Q1.15) to roll, pitch, yaw (Q3.13), fully pipelined.
//
//  channel | dir | fields
//  s_*     | in  | tdata: quat_w, quat_x, quat_y, quat_z
//  m_*     | out | tdata: roll_angle, pitch_angle, yaw_angle
//
// One word accepted per cycle while the output is free or taken. Stages in order:
// products, sums, square, radicand, 31 square root stages, CORDIC pre-rotation
// and iterations, rounding. All stages advance together when the output is
// free or taken; a stalled output holds every stage and drops s_tready.
// rst clears the stage valid bits only.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // roll_angle[15:0], pitch_angle[30:16], yaw_angle[46:31]
);
  import qte_pkg::*;

  localparam int NST   = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
  localparam int DEPTH = 37 + NST;
  localparam int DL_N  = 33;        // sums held from stage 2 to the CORDIC inputs
  localparam int SD_N  = 33 + NST;  // pitch saturation flags to the rounding stage

  logic              en;
  logic [DEPTH-1:0]  vld;

  // Stage 0: products
  logic signed [QW-1:0]     qw, qx, qy, qz;
  logic signed [PROD_W-1:0] p_wx, p_yz, p_xx, p_yy, p_wz, p_xy, p_zz, p_wy, p_zx;
  // Stage 1: sums
  logic signed [SUM_W-1:0]  sr, cr, sy, cy, sp;
  // Stage 2: pitch magnitude square
  logic                     satp, satn;
  logic [59:0]              mag_sq;
  logic [29:0]              mag;
  // Delay lines
  logic signed [SUM_W-1:0]  dl_sr [0:DL_N-1];
  logic signed [SUM_W-1:0]  dl_cr [0:DL_N-1];
  logic signed [SUM_W-1:0]  dl_sy [0:DL_N-1];
  logic signed [SUM_W-1:0]  dl_cy [0:DL_N-1];
  logic signed [SUM_W-1:0]  dl_sp [0:DL_N-1];
  logic                     sd_p [0:SD_N-1];
  logic                     sd_n [0:SD_N-1];
  // Square root pipeline
  logic [SQ_W-1:0]          sq_n [0:SQ_ITER];
  logic [SQ_W-1:0]          sq_r [0:SQ_ITER];
  // CORDIC
  logic signed [ZW-1:0]     z_roll, z_yaw, z_pitch, z_pc;
  logic signed [15:0]       roll_q, yaw_q;
  logic signed [14:0]       pitch_q;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[DEPTH-1];
  assign m_tdata  = {1'b0, yaw_q, pitch_q, roll_q};

  assign qw = s_tdata[15:0];
  assign qx = s_tdata[31:16];
  assign qy = s_tdata[47:32];
  assign qz = s_tdata[63:48];

  // Valid bits travel with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  // Stage 0: nine products at scale 2^30
  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= qw * qx;
      p_yz <= qy * qz;
      p_xx <= qx * qx;
      p_yy <= qy * qy;
      p_wz <= qw * qz;
      p_xy <= qx * qy;
      p_zz <= qz * qz;
      p_wy <= qw * qy;
      p_zx <= qz * qx;
    end
  end

  // Stage 1: doubled sums
  always_ff @(posedge clk) begin
    if (en) begin
      sr <= (SUM_W'(p_wx) + SUM_W'(p_yz)) <<< 1;
      cr <= (SUM_W'(34'sd1) <<< 30) - ((SUM_W'(p_xx) + SUM_W'(p_yy)) <<< 1);
      sy <= (SUM_W'(p_wz) + SUM_W'(p_xy)) <<< 1;
      cy <= (SUM_W'(34'sd1) <<< 30) - ((SUM_W'(p_yy) + SUM_W'(p_zz)) <<< 1);
      sp <= (SUM_W'(p_wy) - SUM_W'(p_zx)) <<< 1;
    end
  end

  // Stage 2: saturation test and square of the pitch argument
  assign mag = sp[SUM_W-1] ? 30'(-sp) : sp[29:0];

  always_ff @(posedge clk) begin
    if (en) begin
      satp   <= (sp >= (SUM_W'(34'sd1) <<< 30));
      satn   <= (sp <= -(SUM_W'(34'sd1) <<< 30));
      mag_sq <= mag * mag;
    end
  end

  // Delay lines for the roll and yaw vectors, pitch numerator and flags
  always_ff @(posedge clk) begin
    if (en) begin
      dl_sr[0] <= sr;
      dl_cr[0] <= cr;
      dl_sy[0] <= sy;
      dl_cy[0] <= cy;
      dl_sp[0] <= sp;
      for (int j = 1; j < DL_N; j++) begin
        dl_sr[j] <= dl_sr[j-1];
        dl_cr[j] <= dl_cr[j-1];
        dl_sy[j] <= dl_sy[j-1];
        dl_cy[j] <= dl_cy[j-1];
        dl_sp[j] <= dl_sp[j-1];
      end
      sd_p[0] <= satp;
      sd_n[0] <= satn;
      for (int j = 1; j < SD_N; j++) begin
        sd_p[j] <= sd_p[j-1];
        sd_n[j] <= sd_n[j-1];
      end
    end
  end

  // Stage 3: radicand 1 - s^2 at scale 2^60
  always_ff @(posedge clk) begin
    if (en) begin
      sq_n[0] <= (SQ_W'(1) << 60) - SQ_W'(mag_sq);
      sq_r[0] <= '0;
    end
  end

  // Square root, one result bit per stage
  for (genvar k = 0; k < SQ_ITER; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (60 - 2 * k);
    logic [SQ_W-1:0] trial;
    assign trial = sq_r[k] + BITV;
    always_ff @(posedge clk) begin
      if (en) begin
        if (sq_n[k] >= trial) begin
          sq_n[k+1] <= sq_n[k] - trial;
          sq_r[k+1] <= (sq_r[k] >> 1) + BITV;
        end else begin
          sq_n[k+1] <= sq_n[k];
          sq_r[k+1] <= sq_r[k] >> 1;
        end
      end
    end
  end

  // Three CORDIC pipelines in lockstep
  qte_cordic #(.STAGES(NST)) u_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (CW'(dl_sr[DL_N-1])),
    .x_in  (CW'(dl_cr[DL_N-1])),
    .z_out (z_roll)
  );

  qte_cordic #(.STAGES(NST)) u_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (CW'(dl_sy[DL_N-1])),
    .x_in  (CW'(dl_cy[DL_N-1])),
    .z_out (z_yaw)
  );

  qte_cordic #(.STAGES(NST)) u_pitch (
    .clk   (clk),
    .en    (en),
    .y_in  (CW'(dl_sp[DL_N-1])),
    .x_in  (CW'({1'b0, sq_r[SQ_ITER][30:0]})),
    .z_out (z_pitch)
  );

  // Round half up from Q28 to Q13 and clamp to +/- lim
  function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] a,
                                                input int lim);
    logic signed [ZW:0]   s;
    logic signed [17:0]   r;
    s = {a[ZW-1], a} + 33'sd16384;
    r = s[ZW:15];
    if (r > lim)  r = 18'(lim);
    if (r < -lim) r = -18'(lim);
    return r[15:0];
  endfunction

  assign z_pc = (z_pitch > HALF_PI_Q28)  ? HALF_PI_Q28  :
                (z_pitch < -HALF_PI_Q28) ? -HALF_PI_Q28 : z_pitch;

  // Final stage: rounding and pitch saturation
  always_ff @(posedge clk) begin
    if (en) begin
      roll_q <= to_q13(z_roll, PI_Q13);
      yaw_q  <= to_q13(z_yaw, PI_Q13);
      if (sd_p[SD_N-1]) begin
        pitch_q <= 15'(HALF_PI_Q13);
      end else if (sd_n[SD_N-1]) begin
        pitch_q <= -15'(HALF_PI_Q13);
      end else begin
        pitch_q <= 15'(to_q13(z_pc, HALF_PI_Q13));
      end
    end
  end

  // Checks
  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (roll_q <= 16'sd25736) && (roll_q >= -16'sd25736))
    else $error("roll out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pitch_q <= 15'sd12868) && (pitch_q >= -15'sd12868))
    else $error("pitch out of range");

  a_sat_excl: assert property (@(posedge clk) disable iff (rst)
    vld[DEPTH-2] |-> !(sd_p[SD_N-1] && sd_n[SD_N-1]))
    else $error("pitch saturated both ways");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(vld))
    else $error("pipeline moved during stall");

endmodule

@@ test/quaternion_to_euler_angles_test.sv @@
// Testbench for the quaternion to Euler angle converter: directed and random words, checked
// against a behavioral CORDIC predictor.
module quaternion_to_euler_angles_test;
  import qte_pkg::*;

  localparam int STAGES = 16;
  localparam int LATENCY = 37 + ((STAGES > 24) ? 24 : STAGES);
  localparam longint LIMIT = 2000000;

  typedef struct packed {
    logic signed [15:0] yaw;
    logic signed [14:0] pitch;
    logic signed [15:0] roll;
  } angles_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [47:0] m_tdata;

  angles_t angle_queue[$];
  int mismatches = 0;
  int checked = 0;
  int sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  longint cycles = 0;

  quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #10 clk = ~clk;

  // floor division by 2^s
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // vectoring CORDIC, result in Q28
  function automatic longint vector_angle(longint yv, longint xv);
    longint ang;
    longint xs;
    longint ys;
    int n;
    ang = 0;
    n = (STAGES > TAB_LEN) ? TAB_LEN : STAGES;
    if (yv == 0) return (xv >= 0) ? 0 : longint'(PI_Q28);
    if (xv < 0) begin
      ang = (yv > 0) ? longint'(PI_Q28) : -longint'(PI_Q28);
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < n; i++) begin
      xs = shr_floor(xv, i);
      ys = shr_floor(yv, i);
      if (yv > 0) begin
        xv = xv + ys;
        yv = yv - xs;
        ang += longint'(atan_tab(i));
      end else begin
        xv = xv - ys;
        yv = yv + xs;
        ang -= longint'(atan_tab(i));
      end
    end
    return ang;
  endfunction

  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = shr_floor(a + (64'sd1 <<< 14), 15);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic angles_t euler_of(logic [63:0] q);
    longint w, x, y, z, sr, cr, sy, cy, sp, c, a;
    longint unsigned mag;
    angles_t e;
    w = longint'($signed(q[15:0]));
    x = longint'($signed(q[31:16]));
    y = longint'($signed(q[47:32]));
    z = longint'($signed(q[63:48]));
    sr = 2 * (w * x + y * z);
    cr = (64'sd1 <<< 30) - 2 * (x * x + y * y);
    sy = 2 * (w * z + x * y);
    cy = (64'sd1 <<< 30) - 2 * (y * y + z * z);
    sp = 2 * (w * y - z * x);
    e.roll = 16'(round_q13(vector_angle(sr, cr), PI_Q13));
    e.yaw = 16'(round_q13(vector_angle(sy, cy), PI_Q13));
    if (sp >= (64'sd1 <<< 30)) e.pitch = 15'(HALF_PI_Q13);
    else if (sp <= -(64'sd1 <<< 30)) e.pitch = 15'(-HALF_PI_Q13);
    else begin
      mag = longint'(sp < 0 ? -sp : sp);
      c = longint'(root_floor((64'd1 << 60) - mag * mag));
      a = vector_angle(sp, c);
      if (a > longint'(HALF_PI_Q28)) a = HALF_PI_Q28;
      if (a < -longint'(HALF_PI_Q28)) a = -longint'(HALF_PI_Q28);
      e.pitch = 15'(round_q13(a, HALF_PI_Q13));
    end
    return e;
  endfunction

  // send one quaternion word, with random idle cycles first; tvalid stays up afterwards
  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {z, y, x, w};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    angle_queue.push_back(euler_of({z, y, x, w}));
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (angle_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  // receiver stall pattern
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // result checker
  always @(posedge clk) begin
    angles_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[46:0];
      if (angle_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_tdata);
      end else begin
        want = angle_queue.pop_front();
        checked++;
        if (got !== want || m_tdata[47] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d (exp/got)",
                     want.roll, got.roll, want.pitch, got.pitch, want.yaw, got.yaw);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    logic [15:0] ext[5] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};
    send_quat(16'h7fff, '0, '0, '0);           // identity
    send_quat(16'h8000, '0, '0, '0);
    send_quat('0, 16'h7fff, '0, '0);           // roll near pi, negative denominator
    send_quat('0, 16'h8000, '0, '0);
    send_quat(16'h5a82, '0, 16'h5a82, '0);     // pitch at +half pi, clamp
    send_quat(16'h5a82, '0, 16'ha57e, '0);     // pitch at -half pi
    send_quat(16'h7fff, '0, 16'h7fff, '0);     // unnormalized, pitch beyond one
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat('0, '0, 16'h7fff, 16'h7fff);     // zero numerator, negative denominator
    send_quat('0, 16'h4000, 16'h4000, 16'hc000);
    for (int i = 0; i < 10; i++)
      send_quat(ext[$urandom_range(4)], ext[$urandom_range(4)],
                ext[$urandom_range(4)], ext[$urandom_range(4)]);
    drain();
  endtask

  // mostly near-unit quaternions, some raw noise
  task automatic test_random(int count, int idle, int stall);
    real a, b, c, d, n;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(3) == 0) begin
        send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        a = real'($signed(16'($urandom)));
        b = real'($signed(16'($urandom)));
        c = real'($signed(16'($urandom)));
        d = real'($signed(16'($urandom)));
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        send_quat(16'($rtoi(a / n * 32767.0)), 16'($rtoi(b / n * 32767.0)),
                  16'($rtoi(c / n * 32767.0)), 16'($rtoi(d / n * 32767.0)));
      end
    end
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    test_directed();
    test_random(500, 0, 0);
    test_random(500, 56, 0);
    test_random(500, 0, 56);
    test_random(500, 7, 7);
    $display("Sent %0d quaternions and checked %0d angle words under four idle patterns.",
             sent, checked);
    if (mismatches == 0 && angle_queue.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
